### design/b32d_pkg.sv
// Package for the Base32 text decoder: item types, character codes and the
// character classifier. No dependencies; used by base32_text_decoder_top.
package b32d_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       final_flag;
        logic [1:0] decode_status;
        logic [7:0] byte_total;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic       is_data;
        logic       is_pad;
        logic       is_bad;
        logic [4:0] value;
    } t_char_class;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_2 = 8'h32;
    localparam logic [7:0] CH_DIGIT_7 = 8'h37;
    localparam logic [7:0] CH_PAD     = 8'h3D;
    // Digits '2'..'7' map to 26..31, so the value is the code minus 24.
    localparam logic [7:0] DIGIT_BIAS = CH_DIGIT_2 - 8'd26;

    localparam logic [7:0] LIMIT_RESET = 8'd64;
    localparam int         FIFO_DEPTH  = 4;

    // Maps one ASCII code to its 5-bit Base32 value and its kind.
    function automatic t_char_class classify(input logic [7:0] c);
        t_char_class k;
        logic [7:0]  diff;
        k    = '0;
        diff = '0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            diff      = c - CH_UPPER_A;
            k.is_data = 1'b1;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            diff      = c - CH_LOWER_A;
            k.is_data = 1'b1;
        end else if (c >= CH_DIGIT_2 && c <= CH_DIGIT_7) begin
            diff      = c - DIGIT_BIAS;
            k.is_data = 1'b1;
        end else if (c == CH_PAD) begin
            k.is_pad = 1'b1;
        end else begin
            k.is_bad = 1'b1;
        end
        k.value = diff[4:0];
        return k;
    endfunction

endpackage

### design/base32_text_decoder_top.sv
// Base32 text decoder, top level: decode step and a four-entry result queue.
// Depends on b32d_pkg for the item types, codes and the classifier.
// A result is written into the result queue when its character is accepted.
// Throughput: one character per cycle while input ready is high; a last character
// yields up to two results, which drain one per cycle from the result queue while i_out_ready is high.
// Input ready is held low while the queue holds more than two results.
// Reset (i_rst_n, synchronous, active low) empties the queue, clears the
// string state and sets the output limit to 64.
module base32_text_decoder_top
    import b32d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // Output limit register.
    logic [7:0]  r_limit;

    // Per-string decode state.
    logic [11:0] r_bit_store, n_bit_store;
    logic [2:0]  r_bits_pending, n_bits_pending;
    logic [7:0]  r_bytes_out, n_bytes_out;
    logic        r_pad_seen, n_pad_seen;
    logic        r_bad_seen, n_bad_seen;
    logic        r_ovf_seen, n_ovf_seen;

    // Result queue: a small circular buffer of result items.
    t_out_item   r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic        in_fire, out_fire;
    t_char_class kind;
    logic [3:0]  bits_sum;
    logic [11:0] store_sh;
    logic [3:0]  bits_left;
    logic [7:0]  byte_val;
    logic        byte_emit;
    t_out_item   byte_item, status_item;
    t_status     status;
    logic [1:0]  push_cnt;
    logic [PTR_W-1:0] wr_ptr_plus1;

    // Leave room for the worst case of two results from one character.
    assign o_in_ready  = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_out_item  = r_fifo[r_rd_ptr];

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;
    assign wr_ptr_plus1 = r_wr_ptr + PTR_W'(1);

    // Decode step: shift the 5-bit value in, take a byte off the top when
    // eight or more bits are pending and the limit allows, and form the status on the last char.
    always_comb begin
        kind           = classify(i_in_item.char_code);
        bits_sum       = {1'b0, r_bits_pending} + 4'd5;
        store_sh       = {r_bit_store[6:0], kind.value};
        bits_left      = bits_sum;
        byte_val       = '0;
        byte_emit      = 1'b0;
        n_bit_store    = r_bit_store;
        n_bits_pending = r_bits_pending;
        n_bytes_out    = r_bytes_out;
        n_pad_seen     = r_pad_seen;
        n_bad_seen     = r_bad_seen;
        n_ovf_seen     = r_ovf_seen;

        if (kind.is_bad) begin
            n_bad_seen = 1'b1;
        end else if (kind.is_pad) begin
            n_pad_seen = 1'b1;
        end else if (!r_pad_seen && !r_bad_seen && !r_ovf_seen) begin
            if (bits_sum >= 4'd8) begin
                if (r_bytes_out >= r_limit) begin
                    // The byte would pass the limit: drop it, stop decoding.
                    n_ovf_seen = 1'b1;
                end else begin
                    bits_left   = bits_sum - 4'd8;
                    byte_val    = 8'(store_sh >> bits_left[2:0]);
                    store_sh    = store_sh & ((12'd1 << bits_left[2:0]) - 12'd1);
                    n_bytes_out = r_bytes_out + 8'd1;
                    byte_emit   = 1'b1;
                end
            end
            n_bit_store    = store_sh;
            n_bits_pending = bits_left[2:0];
        end

        if (n_bad_seen) begin
            status = ST_BAD_CHAR;
        end else if (n_ovf_seen) begin
            status = ST_OVERFLOW;
        end else if (n_bytes_out == 8'd0) begin
            status = ST_EMPTY;
        end else begin
            status = ST_OK;
        end

        byte_item               = '0;
        byte_item.data_byte     = byte_val;
        byte_item.byte_valid    = 1'b1;
        status_item             = '0;
        status_item.final_flag  = 1'b1;
        status_item.decode_status = status;
        status_item.byte_total  = n_bytes_out;

        push_cnt = 2'({1'b0, byte_emit} + {1'b0, i_in_item.last_char});
        if (!in_fire) begin
            push_cnt = 2'd0;
        end

        n_count = r_count + CNT_W'(push_cnt) - CNT_W'(out_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit        <= LIMIT_RESET;
            r_bit_store    <= '0;
            r_bits_pending <= '0;
            r_bytes_out    <= '0;
            r_pad_seen     <= 1'b0;
            r_bad_seen     <= 1'b0;
            r_ovf_seen     <= 1'b0;
            r_wr_ptr       <= '0;
            r_rd_ptr       <= '0;
            r_count        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (in_fire) begin
                if (i_in_item.last_char) begin
                    // The string ends here: all per-string state clears.
                    r_bit_store    <= '0;
                    r_bits_pending <= '0;
                    r_bytes_out    <= '0;
                    r_pad_seen     <= 1'b0;
                    r_bad_seen     <= 1'b0;
                    r_ovf_seen     <= 1'b0;
                end else begin
                    r_bit_store    <= n_bit_store;
                    r_bits_pending <= n_bits_pending;
                    r_bytes_out    <= n_bytes_out;
                    r_pad_seen     <= n_pad_seen;
                    r_bad_seen     <= n_bad_seen;
                    r_ovf_seen     <= n_ovf_seen;
                end
            end
            r_wr_ptr <= r_wr_ptr + PTR_W'(push_cnt);
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    // Queue payload: the byte result, if any, goes first, then the status.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (byte_emit) begin
                r_fifo[r_wr_ptr] <= byte_item;
                if (i_in_item.last_char) begin
                    r_fifo[wr_ptr_plus1] <= status_item;
                end
            end else if (i_in_item.last_char) begin
                r_fifo[r_wr_ptr] <= status_item;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue count exceeds its depth");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_W'(FIFO_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with the count");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_item.last_char) |=>
            (r_bytes_out == 8'd0 && !r_pad_seen && !r_bad_seen && !r_ovf_seen))
        else $error("string state not cleared after the last character");

    a_no_bytes_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pad_seen || r_bad_seen || r_ovf_seen) |-> !byte_emit)
        else $error("byte decoded after decoding stopped");

    a_limit_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        byte_emit |-> (r_bytes_out < r_limit))
        else $error("byte emitted beyond the output limit");
`endif

endmodule
